// ===== rtl/dtrk_pkg.sv =====
package dtrk_pkg;

    localparam int DistW    = 16;
    localparam int PatW     = 12;
    localparam int CntW     = 3;
    localparam int PairW    = 2;
    localparam int CfgAddrW = 2;
    localparam int CfgDataW = 16;

    localparam logic [CntW-1:0] LastStep    = 3'd5;
    localparam logic [CntW-1:0] TriggerStep = 3'd4;

    localparam logic [DistW-1:0] MinDistRst  = 16'd2;
    localparam logic [DistW-1:0] MaxDistRst  = 16'd200;
    localparam logic [PatW-1:0]  LeftPatRst  = 12'd180;
    localparam logic [PatW-1:0]  RightPatRst = 12'd120;

    typedef enum logic [1:0] {
        OP_SAMPLE  = 2'd0,
        OP_ANALYZE = 2'd1,
        OP_CLEAR   = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        DIR_NONE  = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_RIGHT = 2'd2
    } t_dir;

    typedef enum logic [CfgAddrW-1:0] {
        REG_MIN_DIST  = 2'd0,
        REG_MAX_DIST  = 2'd1,
        REG_LEFT_PAT  = 2'd2,
        REG_RIGHT_PAT = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [DistW-1:0] win_lo;
        logic [DistW-1:0] win_hi;
        logic [PatW-1:0]  left_steps;
        logic [PatW-1:0]  right_steps;
    } t_cfg;

    // expected (left, right) pair at one step; steps past the table read as zero
    function automatic logic [PairW-1:0] step_pair(input logic [PatW-1:0] pattern,
                                                   input logic [CntW-1:0] step);
        logic [PairW-1:0] pair;
        case (step)
            3'd0: pair = pattern[1:0];
            3'd1: pair = pattern[3:2];
            3'd2: pair = pattern[5:4];
            3'd3: pair = pattern[7:6];
            3'd4: pair = pattern[9:8];
            3'd5: pair = pattern[11:10];
            default: pair = '0;
        endcase
        return pair;
    endfunction

endpackage

// ===== rtl/dtrk_cfg_regs.sv =====
module dtrk_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [dtrk_pkg::CfgAddrW-1:0] i_cfg_addr,
    input  logic [dtrk_pkg::CfgDataW-1:0] i_cfg_data,
    output dtrk_pkg::t_cfg                o_cfg
);

    dtrk_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.win_lo      <= dtrk_pkg::MinDistRst;
            r_cfg.win_hi      <= dtrk_pkg::MaxDistRst;
            r_cfg.left_steps  <= dtrk_pkg::LeftPatRst;
            r_cfg.right_steps <= dtrk_pkg::RightPatRst;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                dtrk_pkg::REG_MIN_DIST:  r_cfg.win_lo      <= i_cfg_data;
                dtrk_pkg::REG_MAX_DIST:  r_cfg.win_hi      <= i_cfg_data;
                dtrk_pkg::REG_LEFT_PAT:  r_cfg.left_steps  <= i_cfg_data[dtrk_pkg::PatW-1:0];
                dtrk_pkg::REG_RIGHT_PAT: r_cfg.right_steps <= i_cfg_data[dtrk_pkg::PatW-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/dtrk_progress.sv =====
module dtrk_progress (
    input  logic [dtrk_pkg::CntW-1:0]  i_count,
    input  logic [dtrk_pkg::PatW-1:0]  i_pattern,
    input  logic [dtrk_pkg::PairW-1:0] i_prev,
    input  logic [dtrk_pkg::PairW-1:0] i_cur,
    output logic [dtrk_pkg::CntW-1:0]  o_count
);

    logic [dtrk_pkg::CntW-1:0]  count;
    logic [dtrk_pkg::PairW-1:0] at_pair;
    logic [dtrk_pkg::PairW-1:0] fwd_pair;
    logic [dtrk_pkg::PairW-1:0] back_pair;

    always_comb begin
        count     = (i_count > dtrk_pkg::LastStep) ? '0 : i_count;
        at_pair   = dtrk_pkg::step_pair(i_pattern, count);
        fwd_pair  = dtrk_pkg::step_pair(i_pattern, count + 3'd1);
        back_pair = dtrk_pkg::step_pair(i_pattern, count - 3'd1);

        if (count < dtrk_pkg::LastStep && i_prev == at_pair && i_cur == fwd_pair) begin
            o_count = count + 3'd1;
        end else if (count != '0 && i_prev == at_pair && i_cur == back_pair) begin
            o_count = count - 3'd1;
        end else if (i_cur != at_pair) begin
            o_count = '0;
        end else begin
            o_count = count;
        end
    end

endmodule

// ===== rtl/two_sensor_direction_tracker_top.sv =====
// Tracks a movement past two distance sensors. Each transaction on the slave side is a
// sensor sample, an analyze step, a clear or an unused code that changes nothing, and
// yields exactly one result transaction with the held direction and both pattern
// progress counts after that event. The block has two register stages: an input
// register and the tracker state, which also serves as the result register. An accepted
// transaction waits in the input register until the result slot is free, then loads the
// tracker state. A new item can be accepted every cycle as long as results are taken, as
// the progress counters are combinational. Configuration writes take effect on the next
// clock and are meant to happen only while no transaction is in flight.
module two_sensor_direction_tracker_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [dtrk_pkg::CfgAddrW-1:0]       i_cfg_addr,
    input  logic [dtrk_pkg::CfgDataW-1:0]       i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [15:0]                         s_axis_tdata,  // distance
    input  logic [2:0]                          s_axis_tuser,  // operation[1:0], sensor_id[2]
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [7:0]                          m_axis_tdata   // direction_code[1:0],
                                                               // left_count[4:2],
                                                               // right_count[7:5]
);

    dtrk_pkg::t_cfg cfg;

    logic                         r_in_valid;
    logic [1:0]                   r_op;
    logic                         r_sensor;
    logic [dtrk_pkg::DistW-1:0]   r_dist;

    logic                         r_out_valid;
    logic                         r_left_present;
    logic                         r_right_present;
    logic                         r_left_before;
    logic                         r_right_before;
    logic [dtrk_pkg::CntW-1:0]    r_left_progress;
    logic [dtrk_pkg::CntW-1:0]    r_right_progress;
    dtrk_pkg::t_dir               r_held_dir;

    logic                         n_left_present;
    logic                         n_right_present;
    logic                         n_left_before;
    logic                         n_right_before;
    logic [dtrk_pkg::CntW-1:0]    n_left_progress;
    logic [dtrk_pkg::CntW-1:0]    n_right_progress;
    dtrk_pkg::t_dir               n_held_dir;

    logic                         load_out;
    logic                         hit;
    logic [dtrk_pkg::PairW-1:0]   prev_pair;
    logic [dtrk_pkg::PairW-1:0]   cur_pair;
    logic [dtrk_pkg::CntW-1:0]    left_adv;
    logic [dtrk_pkg::CntW-1:0]    right_adv;

    dtrk_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    assign prev_pair = {r_right_before, r_left_before};
    assign cur_pair  = {r_right_present, r_left_present};

    dtrk_progress u_left (
        .i_count   (r_left_progress),
        .i_pattern (cfg.left_steps),
        .i_prev    (prev_pair),
        .i_cur     (cur_pair),
        .o_count   (left_adv)
    );

    dtrk_progress u_right (
        .i_count   (r_right_progress),
        .i_pattern (cfg.right_steps),
        .i_prev    (prev_pair),
        .i_cur     (cur_pair),
        .o_count   (right_adv)
    );

    // the stored state is the result, so it only moves when the result slot is free
    assign load_out      = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || load_out;

    assign hit = (r_dist > cfg.win_lo) && (r_dist < cfg.win_hi);

    always_comb begin
        n_left_present   = r_left_present;
        n_right_present  = r_right_present;
        n_left_before    = r_left_before;
        n_right_before   = r_right_before;
        n_left_progress  = r_left_progress;
        n_right_progress = r_right_progress;
        n_held_dir       = r_held_dir;
        case (r_op)
            dtrk_pkg::OP_SAMPLE: begin
                if (!r_sensor) begin
                    n_left_before  = r_left_present;
                    n_left_present = hit;
                end else begin
                    n_right_before  = r_right_present;
                    n_right_present = hit;
                end
            end
            dtrk_pkg::OP_ANALYZE: begin
                n_left_progress  = left_adv;
                n_right_progress = right_adv;
                if (left_adv == dtrk_pkg::TriggerStep) begin
                    n_held_dir = dtrk_pkg::DIR_LEFT;
                end else if (right_adv == dtrk_pkg::TriggerStep) begin
                    n_held_dir = dtrk_pkg::DIR_RIGHT;
                end else begin
                    n_held_dir = dtrk_pkg::DIR_NONE;
                end
            end
            dtrk_pkg::OP_CLEAR: begin
                n_left_progress  = '0;
                n_right_progress = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_op     <= s_axis_tuser[1:0];
            r_sensor <= s_axis_tuser[2];
            r_dist   <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid      <= 1'b0;
            r_left_present   <= 1'b0;
            r_right_present  <= 1'b0;
            r_left_before    <= 1'b0;
            r_right_before   <= 1'b0;
            r_left_progress  <= '0;
            r_right_progress <= '0;
            r_held_dir       <= dtrk_pkg::DIR_NONE;
        end else begin
            if (load_out) begin
                r_out_valid      <= 1'b1;
                r_left_present   <= n_left_present;
                r_right_present  <= n_right_present;
                r_left_before    <= n_left_before;
                r_right_before   <= n_right_before;
                r_left_progress  <= n_left_progress;
                r_right_progress <= n_right_progress;
                r_held_dir       <= n_held_dir;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_right_progress, r_left_progress, r_held_dir};

endmodule

// ===== sim/tb_two_sensor_direction_tracker_top.sv =====
module tb_two_sensor_direction_tracker_top;

    timeunit 1ns;
    timeprecision 1ps;

    import dtrk_pkg::*;

    localparam logic [1:0] OpReserved   = 2'd3;
    localparam int         ResetCycles  = 12;
    localparam int         HoldCycles   = 300;
    localparam int         StallLimit   = 2000;
    localparam int         MaxReports   = 10;

    typedef struct packed {
        logic [1:0]      dir;
        logic [CntW-1:0] left_cnt;
        logic [CntW-1:0] right_cnt;
    } t_status;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CfgAddrW-1:0] i_cfg_addr;
    logic [CfgDataW-1:0] i_cfg_data;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [15:0]         s_axis_tdata;  // distance
    logic [2:0]          s_axis_tuser;  // operation[1:0], sensor_id[2]
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [7:0]          m_axis_tdata;  // direction_code[1:0], left_count[4:2], right_count[7:5]

    two_sensor_direction_tracker_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // tracker state mirrored on the testbench side
    logic [DistW-1:0] win_min;
    logic [DistW-1:0] win_max;
    logic [PatW-1:0]  left_pat;
    logic [PatW-1:0]  right_pat;
    logic             left_now, right_now, left_prev, right_prev;
    logic [CntW-1:0]  left_prog, right_prog;
    t_dir             held_dir;

    t_status expected_status[$];
    int      status_mismatches;
    int      events_sent;
    int      src_idle_pct;
    int      snk_idle_pct;
    bit      sink_hold_req;
    int      quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [PairW-1:0] pair_at(input logic [PatW-1:0] pat, input int step);
        logic [PatW-1:0] shifted;
        shifted = pat >> (2 * step);
        return shifted[PairW-1:0];
    endfunction

    function automatic logic [CntW-1:0] next_progress(input logic [CntW-1:0] cnt,
                                                      input logic [PatW-1:0] pat,
                                                      input logic [PairW-1:0] prv,
                                                      input logic [PairW-1:0] cur);
        if (cnt < LastStep && prv == pair_at(pat, cnt) && cur == pair_at(pat, cnt + 1))
            return cnt + 3'd1;
        if (cnt > 0 && prv == pair_at(pat, cnt) && cur == pair_at(pat, cnt - 1))
            return cnt - 3'd1;
        if (cur != pair_at(pat, cnt))
            return '0;
        return cnt;
    endfunction

    function automatic void track_event(input logic [1:0] op, input logic sid,
                                        input logic [DistW-1:0] sample_dist);
        logic             hit;
        logic [PairW-1:0] prv, cur;
        t_status          st;
        hit = (sample_dist > win_min) && (sample_dist < win_max);
        case (op)
            OP_SAMPLE: begin
                if (sid) begin
                    right_prev = right_now;
                    right_now  = hit;
                end else begin
                    left_prev = left_now;
                    left_now  = hit;
                end
            end
            OP_ANALYZE: begin
                prv = {right_prev, left_prev};
                cur = {right_now, left_now};
                left_prog  = next_progress(left_prog, left_pat, prv, cur);
                right_prog = next_progress(right_prog, right_pat, prv, cur);
                if (left_prog == TriggerStep)
                    held_dir = DIR_LEFT;
                else if (right_prog == TriggerStep)
                    held_dir = DIR_RIGHT;
                else
                    held_dir = DIR_NONE;
            end
            OP_CLEAR: begin
                // direction is kept, only the counters drop
                left_prog  = '0;
                right_prog = '0;
            end
            default: ;
        endcase
        st.dir       = held_dir;
        st.left_cnt  = left_prog;
        st.right_cnt = right_prog;
        expected_status.push_back(st);
    endfunction

    // distance inside or outside the current window, boundaries now and then
    function automatic logic [DistW-1:0] pick_distance(input logic present);
        int lo, hi;
        lo = int'(win_min) + 1;
        hi = int'(win_max) - 1;
        if (hi < lo)
            return 16'($urandom);
        if (present) begin
            if ($urandom_range(0, 7) == 0)
                return $urandom_range(0, 1) ? 16'(lo) : 16'(hi);
            return 16'($urandom_range(hi, lo));
        end
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? win_min : win_max;
        if ($urandom_range(0, 1))
            return 16'($urandom_range(int'(win_min), 0));
        return 16'($urandom_range(65535, int'(win_max)));
    endfunction

    task automatic send_event(input logic [1:0] op, input logic sid,
                              input logic [DistW-1:0] sample_dist);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sample_dist;
        s_axis_tuser  <= {sid, op};
        do @(posedge i_clk); while (!s_axis_tready);
        track_event(op, sid, sample_dist);
        events_sent++;
    endtask

    task automatic send_noise();
        logic [1:0] op;
        op = 2'($urandom_range(0, 3));
        send_event(op, 1'($urandom),
                   $urandom_range(0, 1) ? pick_distance(1'($urandom)) : 16'($urandom));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_status.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_config(input logic [DistW-1:0] lo, input logic [DistW-1:0] hi,
                                  input logic [PatW-1:0] lp, input logic [PatW-1:0] rp);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= REG_MIN_DIST;
        i_cfg_data <= lo;
        @(posedge i_clk);
        i_cfg_addr <= REG_MAX_DIST;
        i_cfg_data <= hi;
        @(posedge i_clk);
        // upper data bits are dropped by the 12-bit pattern registers
        i_cfg_addr <= REG_LEFT_PAT;
        i_cfg_data <= {4'($urandom), lp};
        @(posedge i_clk);
        i_cfg_addr <= REG_RIGHT_PAT;
        i_cfg_data <= {4'($urandom), rp};
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        win_min   = lo;
        win_max   = hi;
        left_pat  = lp;
        right_pat = rp;
    endtask

    // drive both sensors so each analyze sees (previous step, next step) of the pattern
    task automatic walk_pattern(input logic [PatW-1:0] pat, input int moves, input int back_pct);
        int               pos;
        int               target;
        logic [PairW-1:0] pr;
        pos = 0;
        pr  = pair_at(pat, 0);
        send_event(OP_SAMPLE, 1'b0, pick_distance(pr[0]));
        send_event(OP_SAMPLE, 1'b1, pick_distance(pr[1]));
        for (int k = 0; k < moves; k++) begin
            if (pos == int'(LastStep) || (pos > 0 && $urandom_range(0, 99) < back_pct))
                target = pos - 1;
            else
                target = pos + 1;
            pr = pair_at(pat, target);
            if ($urandom_range(0, 1)) begin
                send_event(OP_SAMPLE, 1'b0, pick_distance(pr[0]));
                send_event(OP_SAMPLE, 1'b1, pick_distance(pr[1]));
            end else begin
                send_event(OP_SAMPLE, 1'b1, pick_distance(pr[1]));
                send_event(OP_SAMPLE, 1'b0, pick_distance(pr[0]));
            end
            if ($urandom_range(0, 19) == 0)
                send_noise();
            send_event(OP_ANALYZE, 1'($urandom), 16'($urandom));
            pos = target;
        end
    endtask

    task automatic test_directed();
        send_event(OP_SAMPLE, 1'b0, 16'd0);
        send_event(OP_SAMPLE, 1'b1, 16'hffff);
        send_event(OP_SAMPLE, 1'b0, MinDistRst);
        send_event(OP_SAMPLE, 1'b1, MaxDistRst);
        send_event(OP_SAMPLE, 1'b0, MinDistRst + 16'd1);
        send_event(OP_SAMPLE, 1'b1, MaxDistRst - 16'd1);
        send_event(OP_ANALYZE, 1'b0, 16'd0);
        send_event(OpReserved, 1'b1, 16'hffff);
        send_event(OP_CLEAR, 1'b0, 16'd0);
        // a walk up to the trigger step of the left pattern raises the left direction
        walk_pattern(left_pat, 4, 0);
        send_event(OP_CLEAR, 1'b1, 16'h5a5a);
        send_event(OP_ANALYZE, 1'b1, 16'ha5a5);
    endtask

    task automatic test_window_edges();
        program_config(16'd0, 16'hffff, 12'hfff, 12'h000);
        send_event(OP_SAMPLE, 1'b0, 16'd0);
        send_event(OP_SAMPLE, 1'b1, 16'd1);
        send_event(OP_SAMPLE, 1'b0, 16'hfffe);
        send_event(OP_SAMPLE, 1'b1, 16'hffff);
        send_event(OP_ANALYZE, 1'b0, 16'd0);
        // min one below max leaves no room for a present sample
        program_config(16'd100, 16'd101, LeftPatRst, RightPatRst);
        send_event(OP_SAMPLE, 1'b0, 16'd100);
        send_event(OP_SAMPLE, 1'b1, 16'd101);
        send_event(OP_ANALYZE, 1'b1, 16'd0);
        program_config(16'hffff, 16'd0, 12'h000, 12'hfff);
        send_event(OP_SAMPLE, 1'b0, 16'h8000);
        send_event(OP_SAMPLE, 1'b1, 16'h7fff);
        send_event(OP_ANALYZE, 1'b0, 16'd0);
        send_event(OP_CLEAR, 1'b0, 16'd0);
    endtask

    task automatic load_random_config();
        logic [DistW-1:0] lo, hi;
        logic [PatW-1:0]  lp, rp;
        case ($urandom_range(0, 9))
            0: begin lo = 16'd0;    hi = 16'hffff;   end
            1: begin lo = 16'hffff; hi = 16'd0;      end
            2: begin lo = 16'($urandom); hi = lo + 16'd1; end
            default: begin
                lo = 16'($urandom_range(0, 30000));
                hi = lo + 16'($urandom_range(2, 30000));
            end
        endcase
        case ($urandom_range(0, 7))
            0: begin lp = 12'h000; rp = 12'hfff; end
            1: begin lp = LeftPatRst; rp = RightPatRst; end
            default: begin lp = 12'($urandom); rp = 12'($urandom); end
        endcase
        program_config(lo, hi, lp, rp);
    endtask

    task automatic test_random_traffic(input int n_events);
        int stop_at;
        stop_at = events_sent + n_events;
        while (events_sent < stop_at) begin
            load_random_config();
            send_event(OP_CLEAR, 1'($urandom), 16'($urandom));
            repeat ($urandom_range(4, 12)) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: walk_pattern(left_pat, $urandom_range(2, 8), 15);
                    4, 5, 6:    walk_pattern(right_pat, $urandom_range(2, 8), 15);
                    7:          send_event(OP_CLEAR, 1'($urandom), 16'($urandom));
                    default:    repeat ($urandom_range(1, 4)) send_noise();
                endcase
            end
        end
    endtask

    task automatic test_backpressure();
        sink_hold_req = 1'b1;
        repeat (3) walk_pattern(right_pat, 6, 10);
        repeat (10) send_noise();
        wait (!sink_hold_req);
        wait_drained();
    endtask

    // result side: random stalls, or a long hold-off on request
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HoldCycles) @(posedge i_clk);
                sink_hold_req = 1'b0;
            end
            m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got) begin
            status_mismatches++;
            if (status_mismatches <= MaxReports)
                $display("%s mismatch: expected %0d, got %0d", name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        t_status want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_status.size() == 0) begin
                status_mismatches++;
                if (status_mismatches <= MaxReports)
                    $display("unexpected result transaction: data %h", m_axis_tdata);
            end else begin
                want = expected_status.pop_front();
                compare_field("direction", want.dir, m_axis_tdata[1:0]);
                compare_field("left_count", want.left_cnt, m_axis_tdata[4:2]);
                compare_field("right_count", want.right_cnt, m_axis_tdata[7:5]);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= '0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        quiet_cycles      = 0;
        status_mismatches = 0;
        events_sent       = 0;
        sink_hold_req     = 1'b0;
        win_min    = MinDistRst;
        win_max    = MaxDistRst;
        left_pat   = LeftPatRst;
        right_pat  = RightPatRst;
        left_now   = 1'b0;
        right_now  = 1'b0;
        left_prev  = 1'b0;
        right_prev = 1'b0;
        left_prog  = '0;
        right_prog = '0;
        held_dir   = DIR_NONE;
        src_idle_pct = 31;
        snk_idle_pct = 78;
        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_window_edges();
        test_random_traffic(650);
        src_idle_pct = 78;
        snk_idle_pct = 31;
        test_random_traffic(650);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_backpressure();
        test_random_traffic(650);

        wait_drained();
        repeat (5) @(posedge i_clk);
        if (status_mismatches == 0 && expected_status.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
